FILE: rtl/core/spc_pkg.sv
// spc_pkg: shared widths, defaults and the stack operation type of the
// stack permutation checker. no dependencies.
`default_nettype none

package spc_pkg;

   // widths fixed by the value range of targets and lengths
   localparam int ValW = 11;
   localparam int NextW = ValW + 1;

   // default stack depth limit
   localparam int MaxLenDefault = 1024;

   // one stack operation as broadcast along the cell chain
   typedef struct packed {
      logic            push;
      logic            pop;
      logic [ValW-1:0] push_value;
   } spc_stack_op_type;

endpackage

`default_nettype wire

FILE: rtl/core/spc_cell.sv
// spc_cell: one entry of the shifting stack, takes its upper neighbor on
// push and its lower neighbor on pop. depends on spc_pkg.
`default_nettype none

module spc_cell (
   input  wire logic                         clock,
   input  wire spc_pkg::spc_stack_op_type    op,
   input  wire logic [spc_pkg::ValW-1:0]     above_value,
   input  wire logic [spc_pkg::ValW-1:0]     below_value,
   output logic      [spc_pkg::ValW-1:0]     cell_value
);
   import spc_pkg::*;

   logic [ValW-1:0] value_ff;
   logic [ValW-1:0] value_in;

   always_comb begin
      value_in = value_ff;
      if (op.push) begin
         value_in = above_value;
      end else if (op.pop) begin
         value_in = below_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign cell_value = value_ff;

endmodule

`default_nettype wire

FILE: rtl/core/spc_cell_chain.sv
// spc_cell_chain: row of spc_cell entries forming a shift stack with its
// top in cell zero. depends on spc_pkg and spc_cell.
`default_nettype none

module spc_cell_chain #(
   parameter int CELL_COUNT = spc_pkg::MaxLenDefault
) (
   input  wire logic                         clock,
   input  wire spc_pkg::spc_stack_op_type    op,
   output logic      [spc_pkg::ValW-1:0]     top_value
);
   import spc_pkg::*;

   logic [ValW-1:0] cell_q [CELL_COUNT];

   for (genvar i = 0; i < CELL_COUNT; i++) begin : g_cell
      logic [ValW-1:0] above;
      logic [ValW-1:0] below;

      if (i == 0) begin : g_first
         assign above = op.push_value;
      end else begin : g_mid_above
         assign above = cell_q[i-1];
      end

      if (i == CELL_COUNT - 1) begin : g_last
         assign below = '0;
      end else begin : g_mid_below
         assign below = cell_q[i+1];
      end

      spc_cell u_cell (
         .clock       (clock),
         .op          (op),
         .above_value (above),
         .below_value (below),
         .cell_value  (cell_q[i])
      );
   end

   assign top_value = cell_q[0];

endmodule

`default_nettype wire

FILE: rtl/core/stack_permutation_checker_unit.sv
// stack_permutation_checker_unit: top level of the stack permutation checker.
// depends on spc_pkg and spc_cell_chain (which uses spc_cell).
`default_nettype none

// Checks whether an order of the values 1..n can be produced by passing
// 1,2,...,n through a single stack. Write n through the csr channel while the
// block is idle (reset value 1, zero acts as 1, values above MAX_LEN
// saturate). Then send the wanted order one target per request; after the
// n-th request one response carries feasible (1 = achievable). Out-of-range or
// repeated targets make the order infeasible. The stack is a row of shifting
// cells with its top in the first cell, so one value can be pushed per cycle:
// a request that pushes several incoming values holds off further requests
// until all are pushed (targets that pop, fail or push one value do not).
// Pushes total fewer than n per order. A request may be taken while a
// response still waits, except the n-th one of an order, which waits for the
// response register to drain.
module stack_permutation_checker_unit #(
   parameter int MAX_LEN = spc_pkg::MaxLenDefault
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   // requests: targets of the wanted order
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic [spc_pkg::ValW-1:0]   req_target_value,
   // responses: one verdict per order
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic                            rsp_feasible,
   // length register
   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic [spc_pkg::ValW-1:0]   csr_seq_length
);
   import spc_pkg::*;

   // lengths never exceed what an 11 bit register holds, so cells are capped
   localparam int LenCap = (1 << ValW) - 1;
   localparam int CellCount = (MAX_LEN < LenCap) ? MAX_LEN : LenCap;

   // controller states
   localparam logic StIdle = 1'b0;
   localparam logic StPush = 1'b1;

   logic            state_ff, state_in;
   logic [ValW-1:0] seq_length_ff, seq_length_in;
   logic [ValW-1:0] stack_count_ff, stack_count_in;
   logic [NextW-1:0] next_incoming_ff, next_incoming_in;
   logic [ValW-1:0] targets_seen_ff, targets_seen_in;
   logic            failed_ff, failed_in;
   logic [ValW-1:0] push_target_ff, push_target_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            rsp_feasible_ff, rsp_feasible_in;

   logic [ValW-1:0] len_eff;
   logic            verdict_due;
   logic            req_take;
   logic            in_range;
   logic            at_or_above;
   logic            pop_match;
   logic            fail_next;
   logic [ValW-1:0] top_value;
   logic [NextW-1:0] next_plus_one;
   spc_stack_op_type stack_op;

   // effective length: zero acts as one, saturate at the stack limit
   always_comb begin
      len_eff = seq_length_ff;
      if (seq_length_ff == '0) begin
         len_eff = ValW'(1);
      end else if (32'(seq_length_ff) > 32'(MAX_LEN)) begin
         len_eff = ValW'(MAX_LEN);
      end
   end

   // the request in hand closes the order
   assign verdict_due = ({1'b0, targets_seen_ff} + NextW'(1)) >= {1'b0, len_eff};

   // the closing request needs a free response register
   assign req_ready = (state_ff == StIdle) &&
                      (!verdict_due || !rsp_valid_ff || rsp_ready);
   assign req_take  = req_valid && req_ready;

   assign in_range    = (req_target_value != '0) && (req_target_value <= len_eff);
   assign at_or_above = {1'b0, req_target_value} >= next_incoming_ff;
   assign pop_match   = (stack_count_ff != '0) && (top_value == req_target_value);
   assign fail_next   = failed_ff || !in_range || (!at_or_above && !pop_match);
   assign next_plus_one = next_incoming_ff + NextW'(1);

   assign csr_ready = 1'b1;

   always_comb begin
      state_in         = state_ff;
      seq_length_in    = seq_length_ff;
      stack_count_in   = stack_count_ff;
      next_incoming_in = next_incoming_ff;
      targets_seen_in  = targets_seen_ff;
      failed_in        = failed_ff;
      push_target_in   = push_target_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_feasible_in  = rsp_feasible_ff;
      stack_op         = '{push: 1'b0, pop: 1'b0, push_value: next_incoming_ff[ValW-1:0]};

      if (csr_valid && csr_ready) begin
         seq_length_in = csr_seq_length;
      end

      unique case (state_ff)
         StIdle: begin
            if (req_take) begin
               if (verdict_due) begin
                  // last target: give the verdict, drop the pending pushes
                  rsp_valid_in     = 1'b1;
                  rsp_feasible_in  = !fail_next;
                  stack_count_in   = '0;
                  next_incoming_in = NextW'(1);
                  targets_seen_in  = '0;
                  failed_in        = 1'b0;
               end else begin
                  targets_seen_in = targets_seen_ff + ValW'(1);
                  failed_in       = fail_next;
                  if (!fail_next) begin
                     if (at_or_above) begin
                        if ({1'b0, req_target_value} == next_incoming_ff) begin
                           // target passes straight through
                           next_incoming_in = {1'b0, req_target_value} + NextW'(1);
                        end else begin
                           // first push happens right away
                           stack_op.push  = 1'b1;
                           stack_count_in = stack_count_ff + ValW'(1);
                           push_target_in = req_target_value;
                           if (next_plus_one == {1'b0, req_target_value}) begin
                              next_incoming_in = {1'b0, req_target_value} + NextW'(1);
                           end else begin
                              next_incoming_in = next_plus_one;
                              state_in         = StPush;
                           end
                        end
                     end else begin
                        stack_op.pop   = 1'b1;
                        stack_count_in = stack_count_ff - ValW'(1);
                     end
                  end
               end
            end
         end
         StPush: begin
            // one incoming value onto the stack per cycle
            stack_op.push  = 1'b1;
            stack_count_in = stack_count_ff + ValW'(1);
            if (next_plus_one == {1'b0, push_target_ff}) begin
               next_incoming_in = {1'b0, push_target_ff} + NextW'(1);
               state_in         = StIdle;
            end else begin
               next_incoming_in = next_plus_one;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= StIdle;
         seq_length_ff    <= ValW'(1);
         stack_count_ff   <= '0;
         next_incoming_ff <= NextW'(1);
         targets_seen_ff  <= '0;
         failed_ff        <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         seq_length_ff    <= seq_length_in;
         stack_count_ff   <= stack_count_in;
         next_incoming_ff <= next_incoming_in;
         targets_seen_ff  <= targets_seen_in;
         failed_ff        <= failed_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      push_target_ff  <= push_target_in;
      rsp_feasible_ff <= rsp_feasible_in;
   end

   // shifting stack, top entry in the first cell
   spc_cell_chain #(
      .CELL_COUNT (CellCount)
   ) u_chain (
      .clock     (clock),
      .op        (stack_op),
      .top_value (top_value)
   );

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_feasible = rsp_feasible_ff;

endmodule

`default_nettype wire
